[rtl/ppm_pkg.sv]
package ppm_pkg;

  localparam int INTERVAL_W = 16;
  localparam int DUTY_W     = 11;
  localparam int IDX_W      = 4;
  localparam int POS_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // (w - min) * 1000 needs 26 bits; the quotient never exceeds 1000
  localparam int PROD_W    = 26;
  localparam int DIV_BITS  = 10;
  localparam int DIV_CNT_W = $clog2(DIV_BITS);

  localparam logic [DUTY_W-1:0]   DUTY_BASE = 11'd1000;
  localparam logic [DIV_BITS-1:0] DUTY_SPAN = 10'd1000;

  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_HIGH = 2'd3;

  localparam logic [INTERVAL_W-1:0] PULSE_MIN_RST = 16'd1000;
  localparam logic [INTERVAL_W-1:0] PULSE_MAX_RST = 16'd2000;
  localparam logic [INTERVAL_W-1:0] SYNC_LOW_RST  = 16'd2000;
  localparam logic [INTERVAL_W-1:0] SYNC_HIGH_RST = 16'd12000;

  typedef struct packed {
    logic accept;     // input transfer this cycle
    logic rd;         // read stored interval of current channel
    logic mul;        // register offset * DUTY_SPAN
    logic div_load;   // seed the divider
    logic div_step;   // one restoring step
    logic load_stat;  // load status result into output register
    logic load_chan;  // load channel result into output register
    logic last;       // channel result is the final one
  } ctrl_cmd_t;

  typedef struct packed {
    logic close_ok;   // accepted interval closes a frame with all channels valid
    logic out_free;   // output register can take a result this cycle
  } dp_stat_t;

endpackage

[rtl/ppm_in_if.sv]
interface ppm_in_if;
  logic                             valid;
  logic                             ready;
  logic [ppm_pkg::INTERVAL_W-1:0]   interval;

  modport source (output valid, output interval, input ready);
  modport sink   (input valid, input interval, output ready);
endinterface

[rtl/ppm_out_if.sv]
interface ppm_out_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [ppm_pkg::IDX_W-1:0]    channel_index;
  logic [ppm_pkg::DUTY_W-1:0]   duty;
  logic                         sync_error;
  logic [ppm_pkg::POS_W-1:0]    frame_position;
  logic                         last;

  modport source (output valid, output kind, output channel_index, output duty,
                  output sync_error, output frame_position, output last,
                  input ready);
  modport sink   (input valid, input kind, input channel_index, input duty,
                  input sync_error, input frame_position, input last,
                  output ready);
endinterface

[rtl/ppm_frame_decoder.sv]
// PPM frame decoder.
// in_ch carries one captured interval (timer ticks) per transfer; out_ch
// carries results. Each accepted interval yields either one status result
// (kind 0) or, when it closes a frame whose channels were all in range,
// CHANNELS channel results (kind 1, index 1..CHANNELS, duty 1000..2000),
// with last marking the final result of that interval.
// Registers pulse_min, pulse_max, sync_low, sync_high are written through
// cfg_we/cfg_index/cfg_data, one per cycle; the user must write them only
// while the block is idle. The block itself does not enforce this. A status
// result is loaded from the status state once the output register is free.
// Each channel result passes store read, multiply, divider seed, 10 one-bit
// divider steps and the output load, in turn on the one shared divider.
// in_ch.ready is high only while the sequencer is idle; one interval may be
// taken while the previous result still waits in the output register.
// If out_ch.ready stays low, the output register holds its result and the
// sequencer parks until it drains. Reset (rst_n low, synchronous) closes any
// open frame, clears the error flag and restores the register defaults.
module ppm_frame_decoder #(
  parameter int CHANNELS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ppm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ppm_pkg::CFG_DATA_W-1:0]      cfg_data,
  ppm_in_if.sink                              in_ch,
  ppm_out_if.source                           out_ch
);

  localparam int CW = $clog2(CHANNELS + 1);

  ppm_pkg::ctrl_cmd_t cmd;
  ppm_pkg::dp_stat_t  stat;
  logic [CW-1:0]      ch;
  logic               in_ready;

  assign in_ch.ready = in_ready;

  ppm_ctrl #(.CHANNELS(CHANNELS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd),
    .ch       (ch)
  );

  ppm_dp #(.CHANNELS(CHANNELS)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_interval        (in_ch.interval),
    .cmd                (cmd),
    .ch                 (ch),
    .stat               (stat),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_kind           (out_ch.kind),
    .out_channel_index  (out_ch.channel_index),
    .out_duty           (out_ch.duty),
    .out_sync_error     (out_ch.sync_error),
    .out_frame_position (out_ch.frame_position),
    .out_last           (out_ch.last)
  );

endmodule

[rtl/ppm_ctrl.sv]
module ppm_ctrl #(
  parameter int CHANNELS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ppm_pkg::dp_stat_t     stat,
  output ppm_pkg::ctrl_cmd_t    cmd,
  output logic [$clog2(CHANNELS+1)-1:0] ch
);

  localparam int CW = $clog2(CHANNELS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_STAT = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]                      state_r, state_nxt;
  logic [CW-1:0]                   ch_r, ch_nxt;
  logic [ppm_pkg::DIV_CNT_W-1:0]   it_r, it_nxt;
  logic                            ch_last;

  assign in_ready = (state_r == S_IDLE);
  assign ch       = ch_r;
  assign ch_last  = (ch_r == CW'(CHANNELS));

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    it_nxt    = it_r;
    cmd       = '0;
    cmd.last  = ch_last;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (stat.close_ok) begin
            ch_nxt    = CW'(1);
            state_nxt = S_RD;
          end else begin
            state_nxt = S_STAT;
          end
        end
      end
      S_STAT: begin
        if (stat.out_free) begin
          cmd.load_stat = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        it_nxt       = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        it_nxt       = it_r + 1'b1;
        if (it_r == ppm_pkg::DIV_CNT_W'(ppm_pkg::DIV_BITS - 1)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.load_chan = 1'b1;
          if (ch_last) begin
            state_nxt = S_IDLE;
          end else begin
            ch_nxt    = ch_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= '0;
      it_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      it_r    <= it_nxt;
    end
  end

endmodule

[rtl/ppm_dp.sv]
module ppm_dp #(
  parameter int CHANNELS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [ppm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ppm_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic [ppm_pkg::INTERVAL_W-1:0]       in_interval,
  input  ppm_pkg::ctrl_cmd_t                   cmd,
  input  logic [$clog2(CHANNELS+1)-1:0]        ch,
  output ppm_pkg::dp_stat_t                    stat,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic                                 out_kind,
  output logic [ppm_pkg::IDX_W-1:0]            out_channel_index,
  output logic [ppm_pkg::DUTY_W-1:0]           out_duty,
  output logic                                 out_sync_error,
  output logic [ppm_pkg::POS_W-1:0]            out_frame_position,
  output logic                                 out_last
);

  localparam int CW = $clog2(CHANNELS + 1);
  localparam int IW = ppm_pkg::INTERVAL_W;
  localparam int QW = ppm_pkg::DIV_BITS;

  // configuration
  logic [IW-1:0] pmin_r, pmax_r, slow_r, shigh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pmin_r  <= ppm_pkg::PULSE_MIN_RST;
      pmax_r  <= ppm_pkg::PULSE_MAX_RST;
      slow_r  <= ppm_pkg::SYNC_LOW_RST;
      shigh_r <= ppm_pkg::SYNC_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ppm_pkg::REG_PULSE_MIN: pmin_r  <= cfg_data;
        ppm_pkg::REG_PULSE_MAX: pmax_r  <= cfg_data;
        ppm_pkg::REG_SYNC_LOW:  slow_r  <= cfg_data;
        ppm_pkg::REG_SYNC_HIGH: shigh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame tracking
  logic          in_frame_r, err_r;
  logic [CW-1:0] slot_r, vc_r, vc_inc;
  logic          big, sync_ok, frame_n, err_n, cnt_hit, closing;

  always_comb begin
    big     = in_interval > pmax_r;
    sync_ok = (in_interval > slow_r) && (in_interval <= shigh_r);
    frame_n = in_frame_r | (big & sync_ok);
    err_n   = big ? ~sync_ok : err_r;
    cnt_hit = (slot_r != '0) && (in_interval <= pmax_r) && (in_interval >= pmin_r);
    vc_inc  = vc_r + CW'(cnt_hit);
    closing = frame_n && (slot_r == CW'(CHANNELS));
  end

  assign stat.close_ok = closing && (vc_inc == CW'(CHANNELS));
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      err_r      <= 1'b0;
      slot_r     <= '0;
      vc_r       <= '0;
    end else if (cmd.accept) begin
      err_r <= err_n;
      if (closing) begin
        in_frame_r <= 1'b0;
        slot_r     <= '0;
        vc_r       <= '0;
      end else if (frame_n) begin
        in_frame_r <= 1'b1;
        slot_r     <= slot_r + 1'b1;
        vc_r       <= vc_inc;
      end
    end
  end

  // interval store, slot 0 holds the sync interval
  logic [IW-1:0] store_mem [CHANNELS+1];
  logic [IW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.accept && frame_n) begin
      store_mem[slot_r] <= in_interval;
    end
    if (cmd.rd) begin
      rd_data_r <= store_mem[ch];
    end
  end

  // clamp and multiply
  logic                       degenerate;
  logic [IW-1:0]              w_cl, off, span;
  logic [ppm_pkg::PROD_W-1:0] prod_r;

  always_comb begin
    degenerate = pmax_r <= pmin_r;
    if (rd_data_r < pmin_r) begin
      w_cl = pmin_r;
    end else if (rd_data_r > pmax_r) begin
      w_cl = pmax_r;
    end else begin
      w_cl = rd_data_r;
    end
    off  = w_cl - pmin_r;
    span = pmax_r - pmin_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= ppm_pkg::PROD_W'(off) * ppm_pkg::PROD_W'(ppm_pkg::DUTY_SPAN);
    end
  end

  // restoring divider, quotient bits shift in as dividend bits shift out
  logic [IW-1:0] rem_r;
  logic [QW-1:0] quo_r;
  logic [IW:0]   trial, trial_sub;
  logic          ge;

  always_comb begin
    trial     = {rem_r, quo_r[QW-1]};
    trial_sub = trial - {1'b0, span};
    ge        = trial >= {1'b0, span};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r <= prod_r[ppm_pkg::PROD_W-1:QW];
      quo_r <= prod_r[QW-1:0];
    end else if (cmd.div_step) begin
      rem_r <= ge ? trial_sub[IW-1:0] : trial[IW-1:0];
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

  // output register
  logic [CW+ppm_pkg::IDX_W-1:0] ch_ext;
  logic [CW+ppm_pkg::POS_W-1:0] slot_ext;
  logic [ppm_pkg::DUTY_W-1:0]   duty_calc;

  assign ch_ext    = {{ppm_pkg::IDX_W{1'b0}}, ch};
  assign slot_ext  = {{ppm_pkg::POS_W{1'b0}}, slot_r};
  assign duty_calc = ppm_pkg::DUTY_BASE +
                     (degenerate ? '0 : ppm_pkg::DUTY_W'(quo_r));

  logic out_valid_r;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_stat || cmd.load_chan) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_stat || cmd.load_chan) begin
      out_sync_error     <= err_r;
      out_frame_position <= slot_ext[ppm_pkg::POS_W-1:0];
    end
    if (cmd.load_stat) begin
      out_kind          <= 1'b0;
      out_channel_index <= '0;
      out_duty          <= '0;
      out_last          <= 1'b1;
    end else if (cmd.load_chan) begin
      out_kind          <= 1'b1;
      out_channel_index <= ch_ext[ppm_pkg::IDX_W-1:0];
      out_duty          <= duty_calc;
      out_last          <= cmd.last;
    end
  end

endmodule

[rtl/ppm_chk.sv]
module ppm_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_kind,
  input logic [ppm_pkg::IDX_W-1:0]     out_channel_index,
  input logic [ppm_pkg::DUTY_W-1:0]    out_duty,
  input logic                          out_last
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_duty) && $stable(out_last))
    else $error("result dropped or changed under stall");

  a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind |-> out_last && out_channel_index == '0 && out_duty == '0)
    else $error("malformed status result");

  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |->
      out_duty >= ppm_pkg::DUTY_BASE && out_duty <= 11'd2000 && out_channel_index != '0)
    else $error("channel result out of range");

  // mid-frame emission keeps the input side closed
  a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind && !out_last |-> !in_ready)
    else $error("input taken during channel emission");

endmodule

bind ppm_frame_decoder ppm_chk u_ppm_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_kind          (out_ch.kind),
  .out_channel_index (out_ch.channel_index),
  .out_duty          (out_ch.duty),
  .out_last          (out_ch.last)
);
